// ===== sv/sdt_pkg.sv =====
package sdt_pkg;

  // table geometry
  localparam int unsigned TABLE_ENTRIES = 256;
  localparam int unsigned IDX_W         = $clog2(TABLE_ENTRIES);

  // busy map: one bit per entry, packed into words of MAP_W bits
  localparam int unsigned MAP_W     = 32;
  localparam int unsigned MAP_BIT_W = $clog2(MAP_W);
  localparam int unsigned MAP_WORDS = (TABLE_ENTRIES + MAP_W - 1) / MAP_W;
  localparam int unsigned MAP_IDX_W = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;

  // descriptor layout
  localparam int unsigned DESC_W   = 64;
  localparam int unsigned ATTR_LSB = 40;
  localparam int unsigned ATTR_W   = 16;

  typedef enum logic [1:0] {
    ACT_SET   = 2'd0,
    ACT_ALLOC = 2'd1,
    ACT_FREE  = 2'd2
  } sdt_action_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_RANGE = 2'd2
  } sdt_status_e;

  typedef struct packed {
    logic [1:0]  action;
    logic [15:0] selector;
    logic [31:0] seg_base;
    logic [31:0] seg_limit;
    logic [15:0] seg_attr;
  } sdt_item_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [15:0]       found_selector;
    logic [DESC_W-1:0] packed_entry;
  } sdt_result_t;

  // top -> busy map
  typedef struct packed {
    logic                 load;     // item accepted: latch word, start read
    logic                 alloc;    // read the first word with a free entry
    logic [MAP_IDX_W-1:0] word;     // word of the addressed entry
    logic                 upd;      // write back one bit of the latched word
    logic [MAP_BIT_W-1:0] bit_sel;
    logic                 val;
    logic                 clr;      // clear sweep write
    logic [MAP_IDX_W-1:0] clr_word;
  } sdt_map_cmd_t;

  // busy map -> top
  typedef struct packed {
    logic                 any_free;
    logic [MAP_IDX_W-1:0] word;
    logic [MAP_BIT_W-1:0] bit_idx;
  } sdt_map_rsp_t;

endpackage

// ===== sv/sdt_ram.sv =====
module sdt_ram #(
  parameter int unsigned Width = 64,
  parameter int unsigned Depth = 256,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/sdt_busy_map.sv =====
module sdt_busy_map import sdt_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  sdt_map_cmd_t cmd_i,
  output sdt_map_rsp_t rsp_o
);

  // word is full once every entry in it is busy
  logic [MAP_WORDS-1:0] full_q;
  logic [MAP_IDX_W-1:0] word_q, word_d;
  logic [MAP_IDX_W-1:0] free_word;
  logic [MAP_IDX_W-1:0] raddr;
  logic [MAP_W-1:0]     rdata, pad, scan, upd_word;
  logic [MAP_BIT_W-1:0] free_bit;
  logic                 we;
  logic [MAP_IDX_W-1:0] waddr;
  logic [MAP_W-1:0]     wdata;

  // entry zero and entries past the table never count as free
  function automatic logic [MAP_W-1:0] pad_mask(logic [MAP_IDX_W-1:0] w);
    int unsigned e;
    logic [MAP_W-1:0] m;
    m = '0;
    for (int b = 0; b < MAP_W; b++) begin
      e = 32'(w) * MAP_W + 32'(b);
      m[b] = (e == 0) || (e >= TABLE_ENTRIES);
    end
    return m;
  endfunction

  always_comb begin
    free_word = '0;
    for (int w = MAP_WORDS - 1; w >= 0; w--) begin
      if (!full_q[w]) free_word = MAP_IDX_W'(w);
    end
  end

  assign raddr  = cmd_i.alloc ? free_word : cmd_i.word;
  assign word_d = cmd_i.load ? raddr : word_q;

  always_ff @(posedge clk_i) begin
    word_q <= word_d;
  end

  assign pad  = pad_mask(word_q);
  assign scan = rdata | pad;

  always_comb begin
    free_bit = '0;
    for (int b = MAP_W - 1; b >= 0; b--) begin
      if (!scan[b]) free_bit = MAP_BIT_W'(b);
    end
  end

  always_comb begin
    upd_word = rdata;
    upd_word[cmd_i.bit_sel] = cmd_i.val;
  end

  assign we    = cmd_i.upd || cmd_i.clr;
  assign waddr = cmd_i.clr ? cmd_i.clr_word : word_q;
  assign wdata = cmd_i.clr ? '0 : upd_word;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      full_q <= '0;
    end else if (cmd_i.upd) begin
      full_q[word_q] <= &(upd_word | pad);
    end
  end

  sdt_ram #(
    .Width (MAP_W),
    .Depth (MAP_WORDS)
  ) u_map_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  assign rsp_o.any_free = ~&full_q;
  assign rsp_o.word     = word_q;
  assign rsp_o.bit_idx  = free_bit;

endmodule

// ===== sv/segment_descriptor_table_top.sv =====
// Segment descriptor table: set / alloc / free on a table of 64-bit descriptors.
// Result strobe (done_o) is registered from S_WB, the write-back state after accept.
// Items go through a memory read-modify-write; busy blocks a new item until it ends.
// Reset: a pass over all TABLE_ENTRIES (256) entries zeroes both memories; busy is
// high until it ends. The receiver cannot stall: each result shows for one cycle.
module segment_descriptor_table_top import sdt_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  sdt_item_t   item_i,
  output logic        done_o,
  output sdt_result_t result_o
);

  localparam logic [1:0] S_CLEAR = 2'd0;
  localparam logic [1:0] S_IDLE  = 2'd1;
  localparam logic [1:0] S_WB    = 2'd2;

  localparam logic [DESC_W-1:0] ATTR_MASK = DESC_W'(64'hFFFF) << ATTR_LSB;

  logic [1:0]        state_q, state_d;
  logic [IDX_W-1:0]  clr_q, clr_d;
  sdt_item_t         req_q;
  logic              free_q;      // a free entry existed when the item was taken
  logic              done_q, done_d;
  sdt_result_t       res_q, res_d;

  logic              accept;
  logic              out_of_range;
  logic [IDX_W-1:0]  req_idx;
  logic [DESC_W-1:0] packed_desc;
  logic [DESC_W-1:0] desc_rdata;
  logic              desc_we;
  logic [IDX_W-1:0]  desc_waddr;
  logic [DESC_W-1:0] desc_wdata;
  sdt_map_cmd_t      map_cmd;
  sdt_map_rsp_t      map_rsp;

  // Pack base / limit / attr. A limit above 0xFFFFF goes page granular.
  function automatic logic [DESC_W-1:0] pack_desc(logic [31:0] base, logic [31:0] limit,
                                                 logic [15:0] attr);
    logic        gran;
    logic [31:0] lim;
    logic [15:0] a;
    gran = limit > 32'hF_FFFF;
    lim  = gran ? (limit >> 12) : limit;
    a    = attr | (gran ? 16'h8000 : 16'h0000) | {4'h0, lim[19:16], 8'h00};
    return {base[31:24], a, base[23:16], base[15:0], lim[15:0]};
  endfunction

  assign busy   = state_q != S_IDLE;
  assign accept = start && !busy;

  assign req_idx      = IDX_W'(req_q.selector[15:3]);
  assign out_of_range = 32'(req_q.selector[15:3]) >= TABLE_ENTRIES;
  assign packed_desc  = pack_desc(req_q.seg_base, req_q.seg_limit, req_q.seg_attr);

  // sequencer
  always_comb begin
    state_d = state_q;
    clr_d   = clr_q;
    unique case (state_q)
      S_CLEAR: begin
        clr_d = clr_q + 1'b1;
        if (32'(clr_q) == TABLE_ENTRIES - 1) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (accept) state_d = S_WB;
      end
      S_WB: begin
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      clr_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q  <= item_i;
      free_q <= map_rsp.any_free;
    end
    res_q <= res_d;
  end

  // write-back stage and clearing pass; memory data for the item is valid in write-back
  always_comb begin
    done_d         = state_q == S_WB;
    res_d          = '0;
    res_d.status   = ST_OK;
    desc_we        = 1'b0;
    desc_waddr     = req_idx;
    desc_wdata     = packed_desc;
    map_cmd        = '0;
    map_cmd.load   = accept;
    map_cmd.alloc  = item_i.action == ACT_ALLOC;
    map_cmd.word   = MAP_IDX_W'(item_i.selector[15:3] >> MAP_BIT_W);
    map_cmd.bit_sel = MAP_BIT_W'(req_q.selector[15:3]);

    if (state_q == S_CLEAR) begin
      desc_we    = 1'b1;
      desc_waddr = clr_q;
      desc_wdata = '0;
      map_cmd.clr      = 32'(clr_q) < MAP_WORDS;
      map_cmd.clr_word = MAP_IDX_W'(clr_q);
    end

    if (state_q == S_WB) begin
      case (sdt_action_e'(req_q.action))
        ACT_SET: begin
          if (out_of_range) begin
            res_d.status = ST_RANGE;
          end else begin
            res_d.packed_entry = packed_desc;
            desc_we            = 1'b1;
            map_cmd.upd        = 1'b1;
            map_cmd.val        = packed_desc[ATTR_LSB +: ATTR_W] != '0;
          end
        end
        ACT_ALLOC: begin
          if (free_q) begin
            res_d.found_selector =
              16'((32'(map_rsp.word) * MAP_W + 32'(map_rsp.bit_idx)) << 3);
          end else begin
            res_d.status = ST_FULL;
          end
        end
        ACT_FREE: begin
          if (out_of_range) begin
            res_d.status = ST_RANGE;
          end else begin
            desc_we     = 1'b1;
            desc_wdata  = desc_rdata & ~ATTR_MASK;
            map_cmd.upd = 1'b1;
            map_cmd.val = 1'b0;
          end
        end
        default: begin
          // unused action code: no change, all-zero ok result
        end
      endcase
    end
  end

  sdt_ram #(
    .Width (DESC_W),
    .Depth (TABLE_ENTRIES)
  ) u_desc_ram (
    .clk_i   (clk_i),
    .we_i    (desc_we),
    .waddr_i (desc_waddr),
    .wdata_i (desc_wdata),
    .raddr_i (IDX_W'(item_i.selector[15:3])),
    .rdata_o (desc_rdata)
  );

  sdt_busy_map u_busy_map (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (map_cmd),
    .rsp_o  (map_rsp)
  );

  assign done_o   = done_q;
  assign result_o = res_q;

  // checks
  a_done_after_wb: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(state_q) == S_WB)
    else $error("result strobe without write-back");

  a_accept_to_wb: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> state_q == S_WB)
    else $error("accepted item did not reach write-back");

  a_wb_to_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_WB |=> done_o && !busy)
    else $error("write-back not followed by result");

  a_alloc_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && result_o.found_selector != '0 |-> result_o.status == ST_OK &&
      result_o.packed_entry == '0)
    else $error("found selector with bad status or payload");

  a_no_accept_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_CLEAR |-> busy && !done_o)
    else $error("activity during clearing pass");

endmodule
